// File: hdl/jdq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the joystick direction quantizer.
// No dependencies; every other file takes names from here by scope.
package jdq_pkg;

    // Group sizes and filter weight
    localparam int READ_SAMPLES  = 4;
    localparam int FILTER_WEIGHT = 4;
    localparam int CAL_SAMPLES   = 100;

    // Datapath widths
    localparam int SAMPLE_W = 12;
    localparam int ACC_W    = 19;
    localparam int CNT_W    = 7;
    localparam int DELTA_W  = 13;
    localparam int MUL_W    = ACC_W + 1;
    localparam int PROD_W   = ACC_W + MUL_W;
    localparam int FQ_W     = SAMPLE_W + 1;
    localparam int FSUM_W   = SAMPLE_W + 2;

    // Exact division of an ACC_W-bit value by a constant: (x * MUL) >> SHIFT
    localparam int CAL_SHIFT    = ACC_W + $clog2(CAL_SAMPLES);
    localparam int CAL_MUL_I    = ((1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int READ_SHIFT   = ACC_W + $clog2(READ_SAMPLES);
    localparam int READ_MUL_I   = ((1 << READ_SHIFT) + READ_SAMPLES - 1) / READ_SAMPLES;
    localparam int FLT_SHIFT    = ACC_W + $clog2(FILTER_WEIGHT);
    localparam int FLT_MUL_I    = ((1 << FLT_SHIFT) + FILTER_WEIGHT - 1) / FILTER_WEIGHT;

    localparam logic [MUL_W-1:0] CAL_MUL  = MUL_W'(CAL_MUL_I);
    localparam logic [MUL_W-1:0] READ_MUL = MUL_W'(READ_MUL_I);
    localparam logic [MUL_W-1:0] FLT_MUL  = MUL_W'(FLT_MUL_I);

    // Filter step: floor((avg - smooth) / W) computed on a positive offset copy
    localparam int FLT_BIAS_I = 1 << SAMPLE_W;
    localparam logic [ACC_W-1:0]  FLT_OFFSET = ACC_W'(FILTER_WEIGHT * FLT_BIAS_I);
    localparam logic [FSUM_W-1:0] FLT_BIAS   = FSUM_W'(FLT_BIAS_I);

    localparam logic [CNT_W-1:0] CAL_SIZE  = CNT_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0] READ_SIZE = CNT_W'(READ_SAMPLES);

    localparam logic [SAMPLE_W-1:0] CENTRE_RESET = SAMPLE_W'(2048);

    // Result queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = OUTQ_AW + 1;

    // Commands / result kinds
    typedef enum logic [1:0] {
        CMD_CAL    = 2'd0,
        CMD_NAV    = 2'd1,
        CMD_NOTE   = 2'd2,
        CMD_IGNORE = 2'd3
    } cmd_t;

    // 4-way direction codes
    localparam logic [2:0] STEER_CENTRE = 3'd0;
    localparam logic [2:0] STEER_RIGHT  = 3'd1;
    localparam logic [2:0] STEER_LEFT   = 3'd2;
    localparam logic [2:0] STEER_UP     = 3'd3;
    localparam logic [2:0] STEER_DOWN   = 3'd4;

    // 8-way note codes
    localparam logic [2:0] NOTE_LEFT       = 3'd0;
    localparam logic [2:0] NOTE_UP         = 3'd1;
    localparam logic [2:0] NOTE_UP_RIGHT   = 3'd2;
    localparam logic [2:0] NOTE_RIGHT      = 3'd3;
    localparam logic [2:0] NOTE_DOWN_RIGHT = 3'd4;
    localparam logic [2:0] NOTE_DOWN       = 3'd5;
    localparam logic [2:0] NOTE_DOWN_LEFT  = 3'd6;
    localparam logic [2:0] NOTE_UP_LEFT    = 3'd7;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_NAV_DEAD_ZONE  = 3'd0;
    localparam logic [2:0] REG_AXIS_MARGIN    = 3'd1;
    localparam logic [2:0] REG_NOTE_DEAD_ZONE = 3'd2;
    localparam logic [2:0] REG_INVERT_X       = 3'd3;
    localparam logic [2:0] REG_INVERT_Y       = 3'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] nav_dead_zone;
        logic [SAMPLE_W-1:0] axis_margin;
        logic [SAMPLE_W-1:0] note_dead_zone;
        logic                invert_x;
        logic                invert_y;
    } cfg_t;

    // Per-lane pipeline control from the group sequencer
    typedef struct packed {
        logic acc_en;   // sample transfer with a real command
        logic fresh;    // sample opens a new group
        logic done;     // sample closes its group
        logic b_cal;    // divide stage holds a calibration group
        logic c_valid;  // filter stage holds a group
        logic c_cal;    // filter stage group is a calibration
    } lane_ctl_t;

    typedef struct packed {
        cmd_t                      kind;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [2:0]                direction;
        logic                      note_valid;
        logic [2:0]                note;
    } result_t;

endpackage

// File: hdl/jdq_axis_lane.sv
`timescale 1ns / 1ps
// One axis lane: group accumulation, constant-divisor average, IIR filter,
// centre subtraction and inversion. Uses jdq_pkg.
module jdq_axis_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jdq_pkg::lane_ctl_t                 ctl,
    input  logic [jdq_pkg::SAMPLE_W-1:0]       sample,
    input  logic                               invert,
    output logic signed [jdq_pkg::DELTA_W-1:0] delta
);

    logic [jdq_pkg::ACC_W-1:0]    acc_reg;
    logic [jdq_pkg::ACC_W-1:0]    acc_next;
    logic [jdq_pkg::ACC_W-1:0]    sum_reg;
    logic [jdq_pkg::SAMPLE_W-1:0] avg_reg;
    logic [jdq_pkg::SAMPLE_W-1:0] avg_next;
    logic [jdq_pkg::SAMPLE_W-1:0] centre_reg;
    logic [jdq_pkg::SAMPLE_W-1:0] smooth_reg;
    logic [jdq_pkg::SAMPLE_W-1:0] smooth_next;
    logic signed [jdq_pkg::DELTA_W-1:0] delta_reg;
    logic signed [jdq_pkg::DELTA_W-1:0] delta_next;

    logic [jdq_pkg::MUL_W-1:0]    div_mul;
    logic [jdq_pkg::PROD_W-1:0]   div_prod;
    logic signed [jdq_pkg::DELTA_W-1:0] flt_diff;
    logic [jdq_pkg::ACC_W-1:0]    flt_num;
    logic [jdq_pkg::PROD_W-1:0]   flt_prod;
    logic [jdq_pkg::FQ_W-1:0]     flt_q;
    logic [jdq_pkg::FSUM_W-1:0]   flt_sum;
    logic signed [jdq_pkg::DELTA_W-1:0] off_diff;

    // Stage A: accumulate
    assign acc_next = ctl.fresh ? jdq_pkg::ACC_W'(sample)
                                : acc_reg + jdq_pkg::ACC_W'(sample);

    // Stage B: average by reciprocal multiply
    assign div_mul  = ctl.b_cal ? jdq_pkg::CAL_MUL : jdq_pkg::READ_MUL;
    assign div_prod = jdq_pkg::PROD_W'(sum_reg) * jdq_pkg::PROD_W'(div_mul);
    assign avg_next = ctl.b_cal ? jdq_pkg::SAMPLE_W'(div_prod >> jdq_pkg::CAL_SHIFT)
                                : jdq_pkg::SAMPLE_W'(div_prod >> jdq_pkg::READ_SHIFT);

    // Stage C: smooth + floor((avg - smooth) / W)
    assign flt_diff = $signed({1'b0, avg_reg}) - $signed({1'b0, smooth_reg});
    assign flt_num  = jdq_pkg::FLT_OFFSET
                    + {{(jdq_pkg::ACC_W - jdq_pkg::DELTA_W){flt_diff[jdq_pkg::DELTA_W-1]}},
                       flt_diff};
    assign flt_prod = jdq_pkg::PROD_W'(flt_num) * jdq_pkg::PROD_W'(jdq_pkg::FLT_MUL);
    assign flt_q    = jdq_pkg::FQ_W'(flt_prod >> jdq_pkg::FLT_SHIFT);
    assign flt_sum  = {2'b00, smooth_reg} + {1'b0, flt_q} - jdq_pkg::FLT_BIAS;
    assign smooth_next = flt_sum[jdq_pkg::SAMPLE_W-1:0];

    // Stage D: offset from centre
    assign off_diff   = $signed({1'b0, smooth_reg}) - $signed({1'b0, centre_reg});
    assign delta_next = invert ? -off_diff : off_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= jdq_pkg::CENTRE_RESET;
            smooth_reg <= jdq_pkg::CENTRE_RESET;
        end
        else if (ctl.c_valid)
        begin
            if (ctl.c_cal)
            begin
                centre_reg <= avg_reg;
                smooth_reg <= avg_reg;
            end
            else
            begin
                smooth_reg <= smooth_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (ctl.acc_en && ctl.done)
        begin
            sum_reg <= acc_next;
        end
        avg_reg   <= avg_next;
        delta_reg <= delta_next;
    end

    assign delta = delta_reg;

endmodule

// File: hdl/jdq_merge.sv
`timescale 1ns / 1ps
// Merge stage: combines both lane deltas into a 4-way direction or an
// 8-way note and forms the result record. Uses jdq_pkg.
module jdq_merge (
    input  jdq_pkg::cmd_t                      kind,
    input  logic signed [jdq_pkg::DELTA_W-1:0] dx,
    input  logic signed [jdq_pkg::DELTA_W-1:0] dy,
    input  jdq_pkg::cfg_t                      cfg,
    output jdq_pkg::result_t                   res
);

    logic [jdq_pkg::DELTA_W-1:0]  neg_x;
    logic [jdq_pkg::DELTA_W-1:0]  neg_y;
    logic [jdq_pkg::SAMPLE_W-1:0] ax;
    logic [jdq_pkg::SAMPLE_W-1:0] ay;
    logic [jdq_pkg::DELTA_W-1:0]  ay_lead;
    logic [jdq_pkg::DELTA_W-1:0]  ax_lead;
    logic                         x_pos;
    logic                         y_pos;
    logic                         left;
    logic                         right;
    logic                         up;
    logic                         down;
    logic [2:0]                   dir4;
    logic                         note_hit;
    logic [2:0]                   note8;

    assign neg_x = -dx;
    assign neg_y = -dy;
    assign ax = dx[jdq_pkg::DELTA_W-1] ? neg_x[jdq_pkg::SAMPLE_W-1:0]
                                       : dx[jdq_pkg::SAMPLE_W-1:0];
    assign ay = dy[jdq_pkg::DELTA_W-1] ? neg_y[jdq_pkg::SAMPLE_W-1:0]
                                       : dy[jdq_pkg::SAMPLE_W-1:0];
    assign x_pos = !dx[jdq_pkg::DELTA_W-1] && (dx != '0);
    assign y_pos = !dy[jdq_pkg::DELTA_W-1] && (dy != '0);

    // margin sums kept one bit wider than the magnitudes
    assign ay_lead = {1'b0, ay} + {1'b0, cfg.axis_margin};
    assign ax_lead = {1'b0, ax} + {1'b0, cfg.axis_margin};

    always_comb
    begin
        priority if (ax < cfg.nav_dead_zone && ay < cfg.nav_dead_zone)
            dir4 = jdq_pkg::STEER_CENTRE;
        else if (ax >= cfg.nav_dead_zone && {1'b0, ax} > ay_lead)
            dir4 = x_pos ? jdq_pkg::STEER_RIGHT : jdq_pkg::STEER_LEFT;
        else if (ay >= cfg.nav_dead_zone && {1'b0, ay} > ax_lead)
            dir4 = y_pos ? jdq_pkg::STEER_UP : jdq_pkg::STEER_DOWN;
        else
            dir4 = jdq_pkg::STEER_CENTRE;
    end

    // magnitude above the zone implies a nonzero value, so sign picks the side
    assign left  = dx[jdq_pkg::DELTA_W-1]  && (ax > cfg.note_dead_zone);
    assign right = !dx[jdq_pkg::DELTA_W-1] && (ax > cfg.note_dead_zone);
    assign down  = dy[jdq_pkg::DELTA_W-1]  && (ay > cfg.note_dead_zone);
    assign up    = !dy[jdq_pkg::DELTA_W-1] && (ay > cfg.note_dead_zone);

    always_comb
    begin
        note_hit = 1'b1;
        priority if (left && up)    note8 = jdq_pkg::NOTE_UP_LEFT;
        else if (right && up)       note8 = jdq_pkg::NOTE_UP_RIGHT;
        else if (right && down)     note8 = jdq_pkg::NOTE_DOWN_RIGHT;
        else if (left && down)      note8 = jdq_pkg::NOTE_DOWN_LEFT;
        else if (up)                note8 = jdq_pkg::NOTE_UP;
        else if (down)              note8 = jdq_pkg::NOTE_DOWN;
        else if (right)             note8 = jdq_pkg::NOTE_RIGHT;
        else if (left)              note8 = jdq_pkg::NOTE_LEFT;
        else
        begin
            note8    = jdq_pkg::NOTE_LEFT;
            note_hit = 1'b0;
        end
    end

    always_comb
    begin
        res            = '0;
        res.kind       = kind;
        unique case (kind)
            jdq_pkg::CMD_NAV:
            begin
                res.delta_x   = dx;
                res.delta_y   = dy;
                res.direction = dir4;
            end
            jdq_pkg::CMD_NOTE:
            begin
                res.delta_x    = dx;
                res.delta_y    = dy;
                res.note_valid = note_hit;
                res.note       = note_hit ? note8 : jdq_pkg::NOTE_LEFT;
            end
            default:
            begin
                res.delta_x = '0;
            end
        endcase
    end

endmodule

// File: hdl/jdq_out_queue.sv
`timescale 1ns / 1ps
// Result queue between the merge stage and the output stream.
// Register-based FIFO of result records. Uses jdq_pkg.
module jdq_out_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  jdq_pkg::result_t            wr_data,
    input  logic                        rd_en,
    output logic                        rd_valid,
    output jdq_pkg::result_t            rd_data,
    output logic [jdq_pkg::OUTQ_CW-1:0] count
);

    jdq_pkg::result_t             mem_reg [jdq_pkg::OUTQ_DEPTH];
    logic [jdq_pkg::OUTQ_AW-1:0]  wr_ptr_reg;
    logic [jdq_pkg::OUTQ_AW-1:0]  rd_ptr_reg;
    logic [jdq_pkg::OUTQ_CW-1:0]  count_reg;
    logic                         pop;

    assign rd_valid = (count_reg != '0);
    assign pop      = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: hdl/joystick_direction_quantizer.sv
`timescale 1ns / 1ps
// Joystick direction quantizer, top level: stream ports, APB registers,
// group sequencer and pipeline control. Uses jdq_pkg, jdq_axis_lane,
// jdq_merge and jdq_out_queue.
//
// One X/Y sample pair is taken per clock while s_tready is high. X and
// Y each run in their own lane: a sample transfer adds into the group sum;
// the closing sample of a group (100 for calibration, 4 for a read) hands
// the sum on to a divide stage, a filter stage that updates the centre or
// the smoothed position, and a centre-subtract stage. The merge stage then
// classifies both deltas into a 4-way direction or an 8-way note, and the
// record waits in an 8-entry result queue; the merge stage writes it from
// the registered lane deltas when the stage-e valid bit is set. s_tready
// falls only when results in the pipeline plus results waiting in the queue
// reach 8; with m_tready held high it never falls. A change of command
// mid-group restarts the group with the new sample; command 3 is taken and
// dropped. Registers should be written only while no group is in flight.
module joystick_direction_quantizer (
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] raw_x, [23:12] raw_y
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [12:0] delta_x, [25:13] delta_y,
                                   // [28:26] direction, [29] note_valid,
                                   // [32:30] note, [39:33] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    jdq_pkg::cfg_t cfg_reg;
    logic          cfg_wr;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nav_dead_zone  <= 12'd600;
            cfg_reg.axis_margin    <= 12'd200;
            cfg_reg.note_dead_zone <= 12'd900;
            cfg_reg.invert_x       <= 1'b0;
            cfg_reg.invert_y       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                jdq_pkg::REG_NAV_DEAD_ZONE:  cfg_reg.nav_dead_zone  <= pwdata[11:0];
                jdq_pkg::REG_AXIS_MARGIN:    cfg_reg.axis_margin    <= pwdata[11:0];
                jdq_pkg::REG_NOTE_DEAD_ZONE: cfg_reg.note_dead_zone <= pwdata[11:0];
                jdq_pkg::REG_INVERT_X:       cfg_reg.invert_x       <= pwdata[0];
                jdq_pkg::REG_INVERT_Y:       cfg_reg.invert_y       <= pwdata[0];
                default:                     ; // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            jdq_pkg::REG_NAV_DEAD_ZONE:  prdata = {20'd0, cfg_reg.nav_dead_zone};
            jdq_pkg::REG_AXIS_MARGIN:    prdata = {20'd0, cfg_reg.axis_margin};
            jdq_pkg::REG_NOTE_DEAD_ZONE: prdata = {20'd0, cfg_reg.note_dead_zone};
            jdq_pkg::REG_INVERT_X:       prdata = {31'd0, cfg_reg.invert_x};
            jdq_pkg::REG_INVERT_Y:       prdata = {31'd0, cfg_reg.invert_y};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- group sequencer ----------------
    jdq_pkg::cmd_t               in_cmd;
    logic                        in_xfer;
    logic                        acc_en;
    logic                        fresh;
    logic                        done;
    logic [jdq_pkg::CNT_W-1:0]   group_size;
    logic [jdq_pkg::CNT_W-1:0]   count_inc;
    logic [jdq_pkg::CNT_W-1:0]   group_count_reg;
    jdq_pkg::cmd_t               group_cmd_reg;

    assign in_cmd     = jdq_pkg::cmd_t'(s_tuser);
    assign in_xfer    = s_tvalid && s_tready;
    assign acc_en     = in_xfer && (in_cmd != jdq_pkg::CMD_IGNORE);
    assign fresh      = (group_count_reg == '0) || (in_cmd != group_cmd_reg);
    assign count_inc  = fresh ? jdq_pkg::CNT_W'(1) : group_count_reg + 1'b1;
    assign group_size = (in_cmd == jdq_pkg::CMD_CAL) ? jdq_pkg::CAL_SIZE
                                                     : jdq_pkg::READ_SIZE;
    assign done       = (count_inc >= group_size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= '0;
            group_cmd_reg   <= jdq_pkg::CMD_CAL;
        end
        else if (acc_en)
        begin
            group_cmd_reg   <= in_cmd;
            group_count_reg <= done ? '0 : count_inc;
        end
    end

    // ---------------- pipeline tracking ----------------
    // b: divide, c: filter, d: centre subtract, e: merge into queue
    logic          vb_reg, vc_reg, vd_reg, ve_reg;
    jdq_pkg::cmd_t cb_reg, cc_reg, cd_reg, ce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            cb_reg <= jdq_pkg::CMD_CAL;
            cc_reg <= jdq_pkg::CMD_CAL;
            cd_reg <= jdq_pkg::CMD_CAL;
            ce_reg <= jdq_pkg::CMD_CAL;
        end
        else
        begin
            vb_reg <= acc_en && done;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            cb_reg <= in_cmd;
            cc_reg <= cb_reg;
            cd_reg <= cc_reg;
            ce_reg <= cd_reg;
        end
    end

    jdq_pkg::lane_ctl_t lane_ctl;

    assign lane_ctl.acc_en  = acc_en;
    assign lane_ctl.fresh   = fresh;
    assign lane_ctl.done    = done;
    assign lane_ctl.b_cal   = (cb_reg == jdq_pkg::CMD_CAL);
    assign lane_ctl.c_valid = vc_reg;
    assign lane_ctl.c_cal   = (cc_reg == jdq_pkg::CMD_CAL);

    // ---------------- lanes ----------------
    logic signed [jdq_pkg::DELTA_W-1:0] dx;
    logic signed [jdq_pkg::DELTA_W-1:0] dy;

    jdq_axis_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (s_tdata[11:0]),
        .invert (cfg_reg.invert_x),
        .delta  (dx)
    );

    jdq_axis_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (s_tdata[23:12]),
        .invert (cfg_reg.invert_y),
        .delta  (dy)
    );

    // ---------------- merge and result queue ----------------
    jdq_pkg::result_t            merged;
    jdq_pkg::result_t            q_data;
    logic [jdq_pkg::OUTQ_CW-1:0] q_count;
    logic [jdq_pkg::OUTQ_CW-1:0] occupancy;

    jdq_merge u_merge (
        .kind (ce_reg),
        .dx   (dx),
        .dy   (dy),
        .cfg  (cfg_reg),
        .res  (merged)
    );

    jdq_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (ve_reg),
        .wr_data  (merged),
        .rd_en    (m_tready),
        .rd_valid (m_tvalid),
        .rd_data  (q_data),
        .count    (q_count)
    );

    // results in flight always have a queue slot reserved
    assign occupancy = q_count
                     + jdq_pkg::OUTQ_CW'(vb_reg) + jdq_pkg::OUTQ_CW'(vc_reg)
                     + jdq_pkg::OUTQ_CW'(vd_reg) + jdq_pkg::OUTQ_CW'(ve_reg);
    assign s_tready  = (occupancy < jdq_pkg::OUTQ_CW'(jdq_pkg::OUTQ_DEPTH));

    assign m_tuser = q_data.kind;
    assign m_tdata = {7'd0, q_data.note, q_data.note_valid, q_data.direction,
                      q_data.delta_y, q_data.delta_x};

endmodule
